[rtl/core/lbvs_pkg.sv]
// Shared constants, opcodes, the lane result type and the saturation helper
// for the linear blend vertex skinning block. No dependencies.
package lbvs_pkg;

  localparam int MAX_JOINTS       = 256;
  localparam int INFLUENCES       = 4;
  localparam int FRAC_BITS        = 16;
  localparam int WEIGHT_BITS      = 16;
  localparam int FIELD_INFLUENCES = 4;
  localparam int MAT_ELEMS        = 16;

  localparam logic [2:0] OP_LOAD_INV   = 3'd0;
  localparam logic [2:0] OP_LOAD_POSE  = 3'd1;
  localparam logic [2:0] OP_LOAD_MODEL = 3'd2;
  localparam logic [2:0] OP_FORM       = 3'd3;
  localparam logic [2:0] OP_VERTEX     = 3'd4;

  // Weighted point of one influence, before the cross-lane sum.
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } lane_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/lbvs_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
// No dependencies.
interface lbvs_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic        [7:0]  joint_index;
  logic        [3:0]  element_index;
  logic signed [31:0] matrix_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [31:0] influence_joints;
  logic        [16:0] weight_a;
  logic        [16:0] weight_b;
  logic        [16:0] weight_c;
  logic        [16:0] weight_d;

  modport source(output valid, opcode, joint_index, element_index, matrix_value,
                 pos_x, pos_y, pos_z, influence_joints,
                 weight_a, weight_b, weight_c, weight_d, input ready);
  modport sink(input valid, opcode, joint_index, element_index, matrix_value,
               pos_x, pos_y, pos_z, influence_joints,
               weight_a, weight_b, weight_c, weight_d, output ready);
endinterface

interface lbvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source(output valid, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface

[rtl/core/linear_blend_vertex_skinning.sv]
// Top level of the four-influence linear blend vertex skinning block.
// Depends on lbvs_pkg, lbvs_if, lbvs_form, lbvs_lane and lbvs_merge.
//
// Usage. Items arrive on in_ch, one beat per item, results leave on out_ch.
// Load beats (inverse bind, pose, model matrix) write one element and leave
// the block free; the next beat may follow at once. A form beat reads the
// joint's pose and inverse-bind matrices, one element pair per cycle, and
// writes the 16 skin elements into every lane's skin copy.
// A vertex beat starts one lane per influence; each lane walks its skin
// matrix one element per cycle and then forms its weighted point.
// The merging stage then adds the lane results in influence order and
// applies the model matrix one element per cycle, or passes the sum through
// when that matrix is all zero. The next beat is taken only once the result
// has been loaded into the output register.
// in_ch.ready is low while a form or vertex beat is in work.
// Results sit in an output register; when the receiver stalls the block
// finishes the next vertex and holds it until the register frees.
// Reset clears the control state and the model matrix; the three matrix
// stores are not cleared and must be written before they are read.
module linear_blend_vertex_skinning #(
  parameter int MAX_JOINTS = lbvs_pkg::MAX_JOINTS,
  parameter int INFLUENCES = lbvs_pkg::INFLUENCES,
  parameter int FRAC_BITS  = lbvs_pkg::FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  lbvs_in_if.sink    in_ch,
  lbvs_out_if.source out_ch
);

  localparam int NL = (INFLUENCES < lbvs_pkg::FIELD_INFLUENCES) ? INFLUENCES
                                                               : lbvs_pkg::FIELD_INFLUENCES;
  localparam int AW = $clog2(MAX_JOINTS * lbvs_pkg::MAT_ELEMS);

  logic          busy_r;
  logic          accept;
  logic          joint_ok;
  logic          ld_inv, ld_pose, model_we, form_start, vtx_start;
  logic          form_done, merge_done;
  logic          skin_we;
  logic [AW-1:0] skin_addr;
  logic signed [31:0] skin_data;
  logic [16:0]   wt [lbvs_pkg::FIELD_INFLUENCES];
  logic [NL-1:0] lane_done;
  lbvs_pkg::lane_res_t lane_res [NL];

  // The block takes one form or vertex beat at a time; loads leave it free.
  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign joint_ok    = 32'(in_ch.joint_index) < MAX_JOINTS;

  assign wt[0] = in_ch.weight_a;
  assign wt[1] = in_ch.weight_b;
  assign wt[2] = in_ch.weight_c;
  assign wt[3] = in_ch.weight_d;

  // Opcode decode. Loads and forms on joints past the store are dropped,
  // and unknown opcodes do nothing.
  always_comb begin
    ld_inv     = 1'b0;
    ld_pose    = 1'b0;
    model_we   = 1'b0;
    form_start = 1'b0;
    vtx_start  = 1'b0;
    if (accept) begin
      unique case (in_ch.opcode)
        lbvs_pkg::OP_LOAD_INV:   ld_inv     = joint_ok;
        lbvs_pkg::OP_LOAD_POSE:  ld_pose    = joint_ok;
        lbvs_pkg::OP_LOAD_MODEL: model_we   = 1'b1;
        lbvs_pkg::OP_FORM:       form_start = joint_ok;
        lbvs_pkg::OP_VERTEX:     vtx_start  = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (form_start || vtx_start) begin
      busy_r <= 1'b1;
    end else if (form_done || merge_done) begin
      busy_r <= 1'b0;
    end
  end

  lbvs_form #(
    .MAX_JOINTS(MAX_JOINTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_form (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_inv   (ld_inv),
    .ld_pose  (ld_pose),
    .ld_addr  (AW'({in_ch.joint_index, in_ch.element_index})),
    .ld_data  (in_ch.matrix_value),
    .start    (form_start),
    .joint    (in_ch.joint_index),
    .skin_we  (skin_we),
    .skin_addr(skin_addr),
    .skin_data(skin_data),
    .done     (form_done)
  );

  // One lane per influence, each with its own copy of the skin store.
  for (genvar g = 0; g < NL; g++) begin : g_lane
    lbvs_lane #(
      .MAX_JOINTS(MAX_JOINTS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr_en  (skin_we),
      .wr_addr(skin_addr),
      .wr_data(skin_data),
      .start  (vtx_start),
      .joint  (in_ch.influence_joints[8*g +: 8]),
      .weight (wt[g]),
      .pos_x  (in_ch.pos_x),
      .pos_y  (in_ch.pos_y),
      .pos_z  (in_ch.pos_z),
      .res    (lane_res[g]),
      .done   (lane_done[g])
    );
  end

  lbvs_merge #(
    .NL       (NL),
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .model_we (model_we),
    .model_idx(in_ch.element_index),
    .model_val(in_ch.matrix_value),
    .start    (&lane_done),
    .lane_res (lane_res),
    .done     (merge_done),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_form_busy: assert property (@(posedge clk) disable iff (!rst_n)
    form_done |-> busy_r) else $error("form finished while idle");
  a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
    merge_done |-> busy_r) else $error("vertex finished while idle");
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(form_done && merge_done)) else $error("form and vertex finished together");
  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> (&lane_done)) else $error("lanes out of step");
`endif

endmodule

[rtl/core/lbvs_form.sv]
// Inverse-bind and pose stores plus the sequencer that forms skin matrices.
// Depends on lbvs_pkg.
module lbvs_form #(
  parameter int MAX_JOINTS = lbvs_pkg::MAX_JOINTS,
  parameter int FRAC_BITS  = lbvs_pkg::FRAC_BITS
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 ld_inv,
  input  logic                                                 ld_pose,
  input  logic [$clog2(MAX_JOINTS*lbvs_pkg::MAT_ELEMS)-1:0]    ld_addr,
  input  logic signed [31:0]                                   ld_data,
  input  logic                                                 start,
  input  logic [7:0]                                           joint,
  output logic                                                 skin_we,
  output logic [$clog2(MAX_JOINTS*lbvs_pkg::MAT_ELEMS)-1:0]    skin_addr,
  output logic signed [31:0]                                   skin_data,
  output logic                                                 done
);

  localparam int DEPTH = MAX_JOINTS * lbvs_pkg::MAT_ELEMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 64 - FRAC_BITS;
  localparam int ACCW  = PW + 2;

  logic signed [31:0] pose_mem [DEPTH];
  logic signed [31:0] inv_mem  [DEPTH];

  logic               run_r;
  logic [5:0]         cnt_r;    // {col, row, k}
  logic [7:0]         joint_r;
  logic signed [31:0] a_r, b_r;
  logic               v1_r, v2_r;
  logic [5:0]         t1_r, t2_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [ACCW-1:0] sum_nxt;
  logic signed [63:0]     full;
  logic               we_r, done_r;
  logic [AW-1:0]      addr_r;
  logic signed [31:0] data_r;

  always_ff @(posedge clk) begin
    if (ld_inv) inv_mem[ld_addr] <= ld_data;
    if (ld_pose) pose_mem[ld_addr] <= ld_data;
    a_r <= pose_mem[AW'({joint_r, cnt_r[1:0], cnt_r[3:2]})];
    b_r <= inv_mem[AW'({joint_r, cnt_r[5:4], cnt_r[1:0]})];
  end

  always_comb begin
    full    = a_r * b_r;
    sum_nxt = ((t2_r[1:0] == 2'd0) ? '0 : acc_r) + ACCW'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      we_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) run_r <= 1'b0;
      end
      v1_r   <= run_r;
      v2_r   <= v1_r;
      we_r   <= v2_r && (t2_r[1:0] == 2'd3);
      done_r <= v2_r && (t2_r == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (start) joint_r <= joint;
    t1_r   <= cnt_r;
    t2_r   <= t1_r;
    prod_r <= PW'(full >>> FRAC_BITS);
    if (v2_r) acc_r <= sum_nxt;
    addr_r <= AW'({joint_r, t2_r[5:4], t2_r[3:2]});
    data_r <= lbvs_pkg::sat32(64'(sum_nxt));
  end

  assign skin_we   = we_r;
  assign skin_addr = addr_r;
  assign skin_data = data_r;
  assign done      = done_r;

endmodule

[rtl/core/lbvs_lane.sv]
// One influence lane: a private copy of the skin store, a point transform
// sequenced one matrix element per cycle, and the weight multiply.
// Depends on lbvs_pkg.
module lbvs_lane #(
  parameter int MAX_JOINTS = lbvs_pkg::MAX_JOINTS,
  parameter int FRAC_BITS  = lbvs_pkg::FRAC_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              wr_en,
  input  logic [$clog2(MAX_JOINTS*lbvs_pkg::MAT_ELEMS)-1:0] wr_addr,
  input  logic signed [31:0]                                wr_data,
  input  logic                                              start,
  input  logic [7:0]                                        joint,
  input  logic [16:0]                                       weight,
  input  logic signed [31:0]                                pos_x,
  input  logic signed [31:0]                                pos_y,
  input  logic signed [31:0]                                pos_z,
  output lbvs_pkg::lane_res_t                               res,
  output logic                                              done
);

  localparam int DEPTH = MAX_JOINTS * lbvs_pkg::MAT_ELEMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 64 - FRAC_BITS;
  localparam int ACCW  = PW + 2;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_r;

  logic               run_r, v1_r, v2_r, fin_r, done_r;
  logic [3:0]         idx_r, idx1_r, idx2_r;
  logic [7:0]         joint_r;
  logic               ok_r;
  logic [16:0]        w_r;
  logic signed [31:0] p_r [3];
  logic signed [31:0] psel;
  logic signed [63:0] full;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACCW-1:0] acc_r [3];
  logic signed [31:0]     t [3];
  logic signed [49:0]     wp [3];
  lbvs_pkg::lane_res_t    res_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[AW'({joint_r, idx_r})];
  end

  always_comb begin
    case (idx1_r[3:2])
      2'd0:    psel = p_r[0];
      2'd1:    psel = p_r[1];
      default: psel = p_r[2];
    endcase
    full = rd_r * psel;
    for (int r = 0; r < 3; r++) begin
      t[r]  = lbvs_pkg::sat32(64'(acc_r[r]));
      wp[r] = t[r] * $signed({1'b0, w_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      idx_r  <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        run_r <= 1'b1;
        idx_r <= '0;
      end else if (run_r) begin
        idx_r <= idx_r + 4'd1;
        if (idx_r == 4'd15) run_r <= 1'b0;
      end
      v1_r   <= run_r;
      v2_r   <= v1_r;
      fin_r  <= v2_r && (idx2_r == 4'd15);
      done_r <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      joint_r <= joint;
      ok_r    <= 32'(joint) < MAX_JOINTS;
      w_r     <= weight;
      p_r[0]  <= pos_x;
      p_r[1]  <= pos_y;
      p_r[2]  <= pos_z;
    end
    idx1_r <= idx_r;
    idx2_r <= idx1_r;
    // The last column is the translation and is added as it stands.
    if (idx1_r[3:2] == 2'd3) begin
      prod_r <= PW'(rd_r);
    end else begin
      prod_r <= PW'(full >>> FRAC_BITS);
    end
    if (v2_r && (idx2_r[1:0] != 2'd3)) begin
      acc_r[idx2_r[1:0]] <= (idx2_r[3:2] == 2'd0) ? ACCW'(prod_r)
                                                  : acc_r[idx2_r[1:0]] + ACCW'(prod_r);
    end
    if (fin_r) begin
      // A zero weight skips the influence, whatever its skin entry holds.
      if (ok_r && (w_r != '0)) begin
        res_r.x <= 33'(wp[0] >>> lbvs_pkg::WEIGHT_BITS);
        res_r.y <= 33'(wp[1] >>> lbvs_pkg::WEIGHT_BITS);
        res_r.z <= 33'(wp[2] >>> lbvs_pkg::WEIGHT_BITS);
      end else begin
        res_r <= '0;
      end
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

[rtl/core/lbvs_merge.sv]
// Merging stage: saturating sum of the lane results in influence order, the
// model-space transform and the output register. Depends on lbvs_pkg, lbvs_if.
module lbvs_merge #(
  parameter int NL        = lbvs_pkg::FIELD_INFLUENCES,
  parameter int FRAC_BITS = lbvs_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                model_we,
  input  logic [3:0]          model_idx,
  input  logic signed [31:0]  model_val,
  input  logic                start,
  input  lbvs_pkg::lane_res_t lane_res [NL],
  output logic                done,
  lbvs_out_if.source          out_ch
);

  localparam int KW   = (NL > 1) ? $clog2(NL) : 1;
  localparam int PW   = 64 - FRAC_BITS;
  localparam int ACCW = PW + 2;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_SUM   = 3'd1;
  localparam logic [2:0] M_XFORM = 3'd2;
  localparam logic [2:0] M_SAT   = 3'd3;
  localparam logic [2:0] M_PUSH  = 3'd4;

  logic [2:0]         state_r;
  logic [KW-1:0]      k_r;
  logic signed [31:0] model_r [16];
  logic signed [31:0] sum_r [3];
  logic signed [31:0] sum_nxt [3];
  logic               nz;
  logic               x_run_r, v1_r;
  logic [3:0]         xidx_r, idx1_r;
  logic signed [31:0] psel;
  logic signed [63:0] full;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACCW-1:0] acc_r [3];
  logic signed [31:0] res_r [3];
  logic               out_valid_r, done_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic               can_load;

  assign can_load = !out_valid_r || out_ch.ready;

  always_comb begin
    nz = 1'b0;
    for (int i = 0; i < 16; i++) nz = nz | (|model_r[i]);
    sum_nxt[0] = lbvs_pkg::sat32(64'(sum_r[0]) + 64'(lane_res[k_r].x));
    sum_nxt[1] = lbvs_pkg::sat32(64'(sum_r[1]) + 64'(lane_res[k_r].y));
    sum_nxt[2] = lbvs_pkg::sat32(64'(sum_r[2]) + 64'(lane_res[k_r].z));
    case (xidx_r[3:2])
      2'd0:    psel = sum_r[0];
      2'd1:    psel = sum_r[1];
      default: psel = sum_r[2];
    endcase
    full = model_r[xidx_r] * psel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= M_IDLE;
      k_r         <= '0;
      x_run_r     <= 1'b0;
      xidx_r      <= '0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      for (int i = 0; i < 16; i++) model_r[i] <= '0;
    end else begin
      done_r <= 1'b0;
      if (model_we) model_r[model_idx] <= model_val;
      if (out_ch.ready) out_valid_r <= 1'b0;
      v1_r <= x_run_r;
      if (x_run_r) begin
        xidx_r <= xidx_r + 4'd1;
        if (xidx_r == 4'd15) x_run_r <= 1'b0;
      end
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            k_r     <= '0;
            state_r <= M_SUM;
          end
        end
        M_SUM: begin
          k_r <= k_r + KW'(1);
          if (k_r == KW'(NL - 1)) begin
            if (nz) begin
              x_run_r <= 1'b1;
              xidx_r  <= '0;
              state_r <= M_XFORM;
            end else begin
              state_r <= M_PUSH;
            end
          end
        end
        M_XFORM: begin
          if (v1_r && (idx1_r == 4'd15)) state_r <= M_SAT;
        end
        M_SAT: begin
          state_r <= M_PUSH;
        end
        M_PUSH: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            done_r      <= 1'b1;
            state_r     <= M_IDLE;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == M_IDLE) && start) begin
      for (int r = 0; r < 3; r++) sum_r[r] <= '0;
    end else if (state_r == M_SUM) begin
      for (int r = 0; r < 3; r++) sum_r[r] <= sum_nxt[r];
      // An all-zero model matrix reads as identity.
      if (k_r == KW'(NL - 1)) begin
        for (int r = 0; r < 3; r++) res_r[r] <= sum_nxt[r];
      end
    end
    idx1_r <= xidx_r;
    if (xidx_r[3:2] == 2'd3) begin
      prod_r <= PW'(model_r[xidx_r]);
    end else begin
      prod_r <= PW'(full >>> FRAC_BITS);
    end
    if (v1_r && (idx1_r[1:0] != 2'd3)) begin
      acc_r[idx1_r[1:0]] <= (idx1_r[3:2] == 2'd0) ? ACCW'(prod_r)
                                                  : acc_r[idx1_r[1:0]] + ACCW'(prod_r);
    end
    if (state_r == M_SAT) begin
      for (int r = 0; r < 3; r++) res_r[r] <= lbvs_pkg::sat32(64'(acc_r[r]));
    end
    if ((state_r == M_PUSH) && can_load) begin
      ox_r <= res_r[0];
      oy_r <= res_r[1];
      oz_r <= res_r[2];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_x = ox_r;
  assign out_ch.out_y = oy_r;
  assign out_ch.out_z = oz_r;
  assign done         = done_r;

endmodule
